// ----- hdl/mwo_pkg.sv -----
// Shared types, widths and constants for the multi-waveform oscillator.
// Holds the quarter-wave sine table, built at elaboration. No dependencies.
package mwo_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int DAC_BITS        = 8;

    localparam int TIME_W     = 32;
    localparam int PHASE_W    = 32;
    localparam int STEP_W     = 31;
    localparam int WAVE_W     = 3;
    localparam int AMP_W      = 8;
    localparam int DAC_W      = 8;
    localparam int LEVEL_W    = PHASE_W + 1;          // level in [0, 2^32]
    localparam int PROD_W     = LEVEL_W + AMP_W;
    localparam int CODE_W     = PROD_W - PHASE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = STEP_W;

    // quarter-wave table: offsets 0 .. QTR inclusive
    localparam int QTR    = 1 << (SINE_TABLE_BITS - 2);
    localparam int IDX_W  = SINE_TABLE_BITS - 1;
    localparam int SINE_W = 31;                       // s in [0, 2^30]

    localparam int unsigned DAC_MAX = (1 << DAC_BITS) - 1;

    localparam logic [LEVEL_W-1:0] HALF_LEVEL = LEVEL_W'(64'd2147483648);
    localparam logic [LEVEL_W-1:0] ONE_LEVEL  = LEVEL_W'(64'd4294967296);

    typedef enum logic [WAVE_W-1:0] {
        WAVE_OFF      = 3'd0,
        WAVE_SINE     = 3'd1,
        WAVE_SAW      = 3'd2,
        WAVE_TRIANGLE = 3'd3,
        WAVE_SQUARE   = 3'd4
    } wave_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP = 2'd0,
        REG_WAVE_SEL   = 2'd1,
        REG_AMPLITUDE  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [STEP_W-1:0] phase_step;
        logic [WAVE_W-1:0] wave_select;
        logic [AMP_W-1:0]  amplitude_level;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        phase_step:      STEP_W'(858993),
        wave_select:     WAVE_OFF,
        amplitude_level: AMP_W'(255)
    };

    typedef logic [QTR:0][SINE_W-1:0] sine_rom_t;

    // sin(x*pi/2) in Q30, odd Taylor series in Horner form, products truncated
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t        rom;
        longint unsigned  x;
        longint unsigned  x2;
        longint unsigned  t;
        rom = '0;
        for (int i = 0; i <= QTR; i++)
        begin
            x  = longint'(i) << (32 - SINE_TABLE_BITS);
            x2 = (x * x) >> 30;
            t  = 64'd172271;
            t  = 64'd5026995    - ((x2 * t) >> 30);
            t  = 64'd85569278   - ((x2 * t) >> 30);
            t  = 64'd693598670  - ((x2 * t) >> 30);
            t  = 64'd1686629713 - ((x2 * t) >> 30);
            t  = (x * t) >> 30;
            if (t > 64'd1073741824)
                t = 64'd1073741824;
            rom[i] = SINE_W'(t);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- hdl/mwo_if.sv -----
// Valid/ready channel interfaces for timestamps in and DAC codes out.
// Depends on mwo_pkg.
interface mwo_in_if
    import mwo_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] time_us;

    modport source (output valid, output time_us, input ready);
    modport sink   (input valid, input time_us, output ready);
endinterface

interface mwo_out_if
    import mwo_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [DAC_W-1:0] dac_value;

    modport source (output valid, output dac_value, input ready);
    modport sink   (input valid, input dac_value, output ready);
endinterface

// ----- hdl/multi_waveform_oscillator_core.sv -----
// Top level of the multi-waveform oscillator: config registers and pipeline.
// Depends on mwo_pkg, mwo_if, mwo_phase, mwo_shaper, mwo_scale.
//
// Usage:
//   sample_in  carries a 32-bit microsecond timestamp per item (valid/ready).
//   sample_out carries one 8-bit DAC code per item (valid/ready).
//   cfg_we/cfg_index/cfg_data write phase_step (0), wave_select (1) and
//   amplitude_level (2); write only while the pipeline is empty.
// Pipeline: phase multiply -> waveform shaping (sine table) -> amplitude
//   multiply and saturate. The last stage is the output register.
// Path: an accepted item is registered in mwo_phase, then in mwo_shaper,
//   then in mwo_scale, whose register drives sample_out.valid and dac_value.
// Throughput: one item per cycle, each stage one per clock, unless stalled.
// Wave select off (or codes 5..7): items are accepted and produce no result.
// Reset: valid bits clear; registers return to 200 Hz step, off, level 255.
// Stall: when sample_out is not taken, each stage holds; a stage with a
//   bubble still takes a new item, so the input stalls only when all three
//   stages are full. Nothing is dropped or repeated.
module multi_waveform_oscillator_core
    import mwo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mwo_in_if.sink                sample_in,
    mwo_out_if.source             sample_out
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // pipeline links
    logic               ph_valid;
    logic               ph_ready;
    logic [PHASE_W-1:0] ph_phase;
    logic               lv_valid;
    logic               lv_ready;
    logic [LEVEL_W-1:0] lv_level;

    // config register file, unknown indexes ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PHASE_STEP: cfg_next.phase_step      = cfg_data[STEP_W-1:0];
                REG_WAVE_SEL:   cfg_next.wave_select     = cfg_data[WAVE_W-1:0];
                REG_AMPLITUDE:  cfg_next.amplitude_level = cfg_data[AMP_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    mwo_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .time_us   (sample_in.time_us),
        .out_valid (ph_valid),
        .out_ready (ph_ready),
        .phase     (ph_phase)
    );

    mwo_shaper u_shaper (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (ph_valid),
        .in_ready  (ph_ready),
        .phase     (ph_phase),
        .out_valid (lv_valid),
        .out_ready (lv_ready),
        .level     (lv_level)
    );

    mwo_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (lv_valid),
        .in_ready  (lv_ready),
        .level     (lv_level),
        .out_valid (sample_out.valid),
        .out_ready (sample_out.ready),
        .dac_value (sample_out.dac_value)
    );

    // a ready sink never backs up the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        sample_out.ready |-> sample_in.ready)
        else $error("input stalled while output is ready");

    // an off waveform never lets an item into the pipeline
    a_off_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_in.valid && sample_in.ready && cfg_reg.wave_select == WAVE_OFF)
        |=> !ph_valid)
        else $error("item entered pipeline while waveform off");

    // a result only appears from the stage before or is held
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        sample_out.valid |-> $past(lv_valid || sample_out.valid))
        else $error("result appeared with no item behind it");

    // square output is either zero or the full amplitude
    a_square_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_out.valid && cfg_reg.wave_select == WAVE_SQUARE)
        |-> (sample_out.dac_value == '0
             || sample_out.dac_value == cfg_reg.amplitude_level
             || sample_out.dac_value == DAC_W'(DAC_MAX)))
        else $error("square output not at a rail");

endmodule

// ----- hdl/mwo_phase.sv -----
// Stage 1: phase = time_us * phase_step, low 32 bits.
// Drops items while the waveform is off. Depends on mwo_pkg.
module mwo_phase
    import mwo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [TIME_W-1:0]  time_us,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PHASE_W-1:0] phase
);

    logic               valid_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               active;

    always_comb
    begin
        case (cfg.wave_select)
            WAVE_SINE, WAVE_SAW, WAVE_TRIANGLE, WAVE_SQUARE: active = 1'b1;
            default:                                         active = 1'b0;
        endcase
    end

    assign phase_next = time_us * PHASE_W'(cfg.phase_step);
    assign in_ready   = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid && active;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            phase_reg <= phase_next;
    end

    assign out_valid = valid_reg;
    assign phase     = phase_reg;

endmodule

// ----- hdl/mwo_shaper.sv -----
// Stage 2: maps phase to a normalized level in [0, 2^32] per waveform.
// Sine from the quarter-wave table in mwo_pkg. Depends on mwo_pkg.
module mwo_shaper
    import mwo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PHASE_W-1:0] phase,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEVEL_W-1:0] level
);

    logic                       valid_reg;
    logic [LEVEL_W-1:0]         level_reg;
    logic [LEVEL_W-1:0]         level_next;
    logic [SINE_TABLE_BITS-1:0] k;
    logic [1:0]                 quad;
    logic [IDX_W-1:0]           offs;
    logic [IDX_W-1:0]           idx;
    logic [SINE_W-1:0]          s;
    logic [LEVEL_W-1:0]         two_s;
    logic [LEVEL_W-1:0]         sine_lvl;
    logic [LEVEL_W-1:0]         two_ph;
    logic [LEVEL_W-1:0]         tri_lvl;

    assign k    = phase[PHASE_W-1 -: SINE_TABLE_BITS];
    assign quad = k[SINE_TABLE_BITS-1 -: 2];
    assign offs = {1'b0, k[SINE_TABLE_BITS-3:0]};
    // odd quadrants run the quarter wave backwards
    assign idx  = quad[0] ? (IDX_W'(QTR) - offs) : offs;
    assign s    = SINE_ROM[idx];
    assign two_s    = {1'b0, s, 1'b0};
    assign sine_lvl = quad[1] ? (HALF_LEVEL - two_s) : (HALF_LEVEL + two_s);

    assign two_ph  = {phase, 1'b0};
    assign tri_lvl = phase[PHASE_W-1] ? ((ONE_LEVEL << 1) - two_ph) : two_ph;

    always_comb
    begin
        case (cfg.wave_select)
            WAVE_SINE:     level_next = sine_lvl;
            WAVE_SAW:      level_next = {1'b0, phase};
            WAVE_TRIANGLE: level_next = tri_lvl;
            WAVE_SQUARE:   level_next = ({1'b0, phase} > HALF_LEVEL) ? ONE_LEVEL : '0;
            default:       level_next = '0;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            level_reg <= level_next;
    end

    assign out_valid = valid_reg;
    assign level     = level_reg;

endmodule

// ----- hdl/mwo_scale.sv -----
// Stage 3: code = (level * amplitude) >> 32, saturated to the DAC range.
// Acts as the output register. Depends on mwo_pkg.
module mwo_scale
    import mwo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [LEVEL_W-1:0] level,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DAC_W-1:0]   dac_value
);

    logic               valid_reg;
    logic [DAC_W-1:0]   dac_reg;
    logic [DAC_W-1:0]   dac_next;
    logic [PROD_W-1:0]  prod;
    logic [CODE_W-1:0]  code;

    assign prod = PROD_W'(level) * PROD_W'(cfg.amplitude_level);
    assign code = prod[PROD_W-1 -: CODE_W];

    assign dac_next = (32'(code) > DAC_MAX) ? DAC_W'(DAC_MAX) : DAC_W'(code);

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            dac_reg <= dac_next;
    end

    assign out_valid = valid_reg;
    assign dac_value = dac_reg;

endmodule

// ----- test/osc_checker.sv -----
// Scoreboard for the multi-waveform oscillator. It watches the register
// writes and both item channels, predicts every DAC code and compares in order.
// Depends on mwo_pkg.
module osc_checker
    import mwo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [TIME_W-1:0]     in_time_us,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [DAC_W-1:0]      out_dac_value,
    output int                    mismatch_count,
    output int                    expected_left
);

    localparam longint unsigned Q30_ONE  = 64'd1073741824;
    localparam longint unsigned Q32_HALF = 64'd2147483648;
    localparam longint unsigned Q32_ONE  = 64'd4294967296;

    // sin(x*pi/2) series terms, Q30
    localparam longint unsigned K1 = 64'd1686629713;
    localparam longint unsigned K3 = 64'd693598670;
    localparam longint unsigned K5 = 64'd85569278;
    localparam longint unsigned K7 = 64'd5026995;
    localparam longint unsigned K9 = 64'd172271;

    cfg_t             osc_cfg;
    logic [DAC_W-1:0] dac_expected[$];
    logic [DAC_W-1:0] oldest;
    int               predicted;

    function automatic longint unsigned quarter_sine(longint unsigned x);
        longint unsigned xsq;
        longint unsigned acc;
        xsq = (x * x) >> 30;
        acc = K9;
        acc = K7 - ((xsq * acc) >> 30);
        acc = K5 - ((xsq * acc) >> 30);
        acc = K3 - ((xsq * acc) >> 30);
        acc = K1 - ((xsq * acc) >> 30);
        acc = (x * acc) >> 30;
        return (acc > Q30_ONE) ? Q30_ONE : acc;
    endfunction

    // DAC code for one timestamp, or -1 when the wave select gives no item
    function automatic int predict_code(cfg_t c, logic [TIME_W-1:0] t);
        longint unsigned phase;
        longint unsigned level;
        longint unsigned code;
        longint unsigned tab_idx;
        longint unsigned quad;
        longint unsigned x;
        longint unsigned s;
        phase = (64'(t) * 64'(c.phase_step)) & 64'hFFFF_FFFF;
        case (c.wave_select)
            WAVE_SINE:
            begin
                tab_idx = phase >> (PHASE_W - SINE_TABLE_BITS);
                quad    = (tab_idx >> (SINE_TABLE_BITS - 2)) & 64'd3;
                x       = (tab_idx & 64'(QTR - 1)) << (PHASE_W - SINE_TABLE_BITS);
                if (quad[0])
                    x = Q30_ONE - x;
                s     = quarter_sine(x);
                level = quad[1] ? (Q32_HALF - 2 * s) : (Q32_HALF + 2 * s);
            end
            WAVE_SAW:
                level = phase;
            WAVE_TRIANGLE:
                level = (phase < Q32_HALF) ? (2 * phase) : (2 * Q32_ONE - 2 * phase);
            WAVE_SQUARE:
                level = (phase > Q32_HALF) ? Q32_ONE : 64'd0;
            default:
                return -1;
        endcase
        code = (level * 64'(c.amplitude_level)) >> 32;
        if (code > 64'(DAC_MAX))
            code = 64'(DAC_MAX);
        return int'(code & 64'hFF);
    endfunction

    task automatic report_mismatch(input string what);
        $display("osc_checker: %0t: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osc_cfg = CFG_RESET;
            dac_expected.delete();
            mismatch_count = 0;
            expected_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted = predict_code(osc_cfg, in_time_us);
                if (predicted >= 0)
                    dac_expected.push_back(DAC_W'(predicted));
            end
            if (out_valid && out_ready)
            begin
                if (dac_expected.size() == 0)
                    report_mismatch($sformatf("dac_value %0d with no item expected",
                                              out_dac_value));
                else
                begin
                    oldest = dac_expected.pop_front();
                    if (out_dac_value !== oldest)
                        report_mismatch($sformatf("dac_value got %0d, expected %0d",
                                                  out_dac_value, oldest));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PHASE_STEP: osc_cfg.phase_step      = cfg_data[STEP_W-1:0];
                    REG_WAVE_SEL:   osc_cfg.wave_select     = cfg_data[WAVE_W-1:0];
                    REG_AMPLITUDE:  osc_cfg.amplitude_level = cfg_data[AMP_W-1:0];
                    default: ;
                endcase
            end
            expected_left <= dac_expected.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
// Top of the oscillator testbench: clock, reset, register writes, timestamp
// stimulus, result sink with stalls, watchdog and verdict.
// Depends on mwo_pkg, mwo_if, multi_waveform_oscillator_core, osc_checker.
module tb_top;
    import mwo_pkg::*;

    localparam int OSC_LATENCY    = 3;      // accept to result
    localparam int RANDOM_ITEMS   = 1750;   // items that make a result
    localparam int HOLD_CYCLES    = 80;     // long receiver hold-off, fills the pipe
    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no item moving

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mwo_in_if  sample_in_ch ();
    mwo_out_if sample_out_ch ();

    int fail_count;
    int expected_left;
    int idle_cycles;

    // shared with the sink process
    int hold_cycles = 0;
    bit no_gaps     = 1'b0;

    always #5 clk = ~clk;

    multi_waveform_oscillator_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in_ch),
        .sample_out (sample_out_ch)
    );

    osc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (sample_in_ch.valid),
        .in_ready       (sample_in_ch.ready),
        .in_time_us     (sample_in_ch.time_us),
        .out_valid      (sample_out_ch.valid),
        .out_ready      (sample_out_ch.ready),
        .out_dac_value  (sample_out_ch.dac_value),
        .mismatch_count (fail_count),
        .expected_left  (expected_left)
    );

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((sample_in_ch.valid && sample_in_ch.ready) ||
                 (sample_out_ch.valid && sample_out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    // Result sink: random stall before each item, plus one long hold-off
    // when the stimulus asks for it. The hold is counted here, not in the
    // stimulus, so the sender keeps offering items meanwhile.
    initial
    begin : result_sink
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                sample_out_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                sample_out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            sample_out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(sample_out_ch.valid && sample_out_ch.ready))
                @(posedge clk);
        end
    end

    // Offer one timestamp after a random gap; returns at the accepting edge.
    // Valid stays high on return so back-to-back items need no toggle.
    task automatic send_timestamp(input logic [TIME_W-1:0] t);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            sample_in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_in_ch.valid   <= 1'b1;
        sample_in_ch.time_us <= t;
        @(posedge clk);
        while (!sample_in_ch.ready)
            @(posedge clk);
    endtask

    // Stop offering, wait for every predicted code, then let the pipe empty.
    // The extra cycles cover items in flight that make no result (wave off).
    task automatic wait_until_drained();
        sample_in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (OSC_LATENCY + 2) @(posedge clk);
    endtask

    // All three registers, one per cycle; only called with the pipe idle.
    task automatic set_config(input logic [STEP_W-1:0] step,
                              input logic [WAVE_W-1:0] wave,
                              input logic [AMP_W-1:0]  amp);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PHASE_STEP;
        cfg_data  <= CFG_DATA_W'(step);
        @(posedge clk);
        cfg_index <= REG_WAVE_SEL;
        cfg_data  <= CFG_DATA_W'(wave);
        @(posedge clk);
        cfg_index <= REG_AMPLITUDE;
        cfg_data  <= CFG_DATA_W'(amp);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [STEP_W-1:0] step;
        logic [WAVE_W-1:0] wave;
        logic [AMP_W-1:0]  amp;
        logic [TIME_W-1:0] t;
        int                pick;
        int                n_items;
        int                productive;
        int                phase_num;
        bit                producing;

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_PHASE_STEP;
        cfg_data             <= '0;
        sample_in_ch.valid   <= 1'b0;
        sample_in_ch.time_us <= '0;
        sample_out_ch.ready  <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // Reset state is off: timestamps are taken, nothing comes back.
        send_timestamp(32'h0000_0000);
        send_timestamp(32'hFFFF_FFFF);
        wait_until_drained();

        // Sine with step 1: phase equals the timestamp, so the quadrant
        // edges and the top of the table are hit directly.
        set_config(STEP_W'(1), WAVE_SINE, AMP_W'(255));
        send_timestamp(32'h0000_0000);
        send_timestamp(32'h4000_0000);
        send_timestamp(32'h8000_0000);
        send_timestamp(32'hC000_0000);
        send_timestamp(32'hFFFF_FFFF);
        wait_until_drained();

        // Square: exactly half a cycle gives 0, just past it full scale.
        set_config(STEP_W'(1), WAVE_SQUARE, AMP_W'(255));
        send_timestamp(32'h8000_0000);
        send_timestamp(32'h8000_0001);
        send_timestamp(32'h7FFF_FFFF);
        send_timestamp(32'hFFFF_FFFF);
        wait_until_drained();

        // Saw with the largest step: the phase product wraps.
        set_config({STEP_W{1'b1}}, WAVE_SAW, AMP_W'(128));
        send_timestamp(32'hFFFF_FFFF);
        send_timestamp(32'h0000_0003);
        send_timestamp(32'h1234_5678);
        wait_until_drained();

        // Triangle around its peak.
        set_config(STEP_W'(1), WAVE_TRIANGLE, AMP_W'(255));
        send_timestamp(32'h7FFF_FFFF);
        send_timestamp(32'h8000_0000);
        send_timestamp(32'h4000_0000);
        wait_until_drained();

        // Unused wave codes act as off.
        for (int w = 1; w <= 3; w++)
        begin
            set_config(STEP_W'(1), WAVE_W'(WAVE_SQUARE + w), AMP_W'(255));
            send_timestamp($urandom);
            wait_until_drained();
        end

        // Zero step and zero level.
        set_config('0, WAVE_SAW, '0);
        send_timestamp(32'hFFFF_FFFF);
        wait_until_drained();

        // ---- random part: phases of one setting each ----
        productive = 0;
        phase_num  = 0;
        while (productive < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0: step = '0;
                1: step = {STEP_W{1'b1}};
                2: step = STEP_W'($urandom_range(1, 1000));
                // audio range, roughly freq * 2^32 / 1e6
                3: step = STEP_W'($urandom_range(20, 20000) * 4295);
                4: step = {STEP_W{1'b1}} - STEP_W'($urandom_range(0, 1000));
                default: step = STEP_W'($urandom);
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 8)
                wave = WAVE_W'(WAVE_SINE + pick % 4);
            else if (pick == 8)
                wave = WAVE_OFF;
            else
                wave = WAVE_W'(WAVE_SQUARE + $urandom_range(1, 3));
            producing = wave inside {[WAVE_SINE:WAVE_SQUARE]};
            // the pressure phases need results to fill the pipe
            if ((phase_num == 1 || phase_num == 3) && !producing)
            begin
                wave      = WAVE_TRIANGLE;
                producing = 1'b1;
            end
            case ($urandom_range(0, 3))
                0: amp = '0;
                1: amp = '1;
                2: amp = AMP_W'(1);
                default: amp = AMP_W'($urandom_range(0, 255));
            endcase

            set_config(step, wave, amp);
            no_gaps = (phase_num % 3 == 2);
            n_items = producing ? $urandom_range(100, 250) : 20;
            if (phase_num == 1)
                hold_cycles = HOLD_CYCLES;

            for (int i = 0; i < n_items; i++)
            begin
                case ($urandom_range(0, 5))
                    0, 1, 2: t = $urandom;
                    3: t = TIME_W'($urandom_range(0, 1023));
                    4: t = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 1023));
                    default: t = 32'h8000_0000 + TIME_W'($urandom_range(0, 64)) - 32'd32;
                endcase
                send_timestamp(t);
                // sender waits mid-phase until every result is back
                if (phase_num == 3 && i == n_items / 2)
                    wait_until_drained();
            end
            wait_until_drained();
            if (producing)
                productive += n_items;
            phase_num++;
        end

        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
